/* hdl/svb_pkg.sv */
// ----------------------------------------------------------------------------
// svb_pkg
// Shared types, opcodes and helpers of the string buffer unit.
// ----------------------------------------------------------------------------
package svb_pkg;

    localparam int STR_CAPACITY_DEF = 30;
    localparam int NUM_SLOTS_DEF    = 16;
    // slot fields inside the command queue are sized for the largest store
    localparam int SLOT_W           = 8;

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_LENGTH = 3'd1;
    localparam logic [2:0] OP_FILL   = 3'd2;
    localparam logic [2:0] OP_PUTC   = 3'd3;
    localparam logic [2:0] OP_APPEND = 3'd4;
    localparam logic [2:0] OP_MASK   = 3'd5;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] dst_slot;
        logic [3:0] src_slot;
        logic [7:0] value_byte;
        logic [7:0] fill_offset;
        logic [7:0] zero_char;
        logic [7:0] one_char;
    } t_req;

    typedef struct packed {
        logic [4:0] length;
        logic       illegal_op;
    } t_rsp;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [2:0]        op;
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] src;
        logic [7:0]        val;
        logic [7:0]        offset;
        logic [7:0]        c0;
        logic [7:0]        c1;
        logic              self_copy;
        logic              illegal;
        logic [3:0]        nbits;
    } t_cmd;

    // number of mask characters: position of the top set bit plus one
    function automatic logic [3:0] mask_width(input logic [7:0] val);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (val[i]) begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

/* hdl/svb_front.sv */
// ----------------------------------------------------------------------------
// svb_front
// Takes requests, maps slots, classifies the opcode and queues the command.
// ----------------------------------------------------------------------------
module svb_front import svb_pkg::*; #(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    input  logic i_pop,
    output logic o_cmd_valid,
    output t_cmd o_cmd
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic [SW-1:0] slot_map [16];
    t_cmd          cmd;
    t_cmd          r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    // slot numbers wrap around the store
    for (genvar gi = 0; gi < 16; gi++) begin : g_map
        assign slot_map[gi] = SW'(gi % NUM_SLOTS);
    end

    always_comb begin
        cmd           = '0;
        cmd.op        = i_req.op;
        cmd.dst       = SLOT_W'(slot_map[i_req.dst_slot]);
        cmd.src       = SLOT_W'(slot_map[i_req.src_slot]);
        cmd.val       = i_req.value_byte;
        cmd.offset    = i_req.fill_offset;
        cmd.c0        = i_req.zero_char;
        cmd.c1        = i_req.one_char;
        cmd.self_copy = (slot_map[i_req.dst_slot] == slot_map[i_req.src_slot]);
        cmd.illegal   = !(i_req.op == OP_CLEAR  || i_req.op == OP_LENGTH ||
                          i_req.op == OP_FILL   || i_req.op == OP_PUTC   ||
                          i_req.op == OP_APPEND || i_req.op == OP_MASK);
        cmd.nbits     = mask_width(i_req.value_byte);
    end

    assign busy        = (r_cnt == 2'd2);
    assign push        = start && !busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hdl/svb_exec.sv */
// ----------------------------------------------------------------------------
// svb_exec
// Carries out queued commands on the string store, one byte per cycle.
// ----------------------------------------------------------------------------
module svb_exec import svb_pkg::*; #(
    parameter int STR_CAPACITY = STR_CAPACITY_DEF,
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_pop,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam int DEPTH = NUM_SLOTS * STR_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW    = $clog2(STR_CAPACITY + 1);
    localparam logic [LW-1:0] CAP = LW'(STR_CAPACITY);

    typedef enum logic [4:0] {
        S_INIT = 5'b00001,
        S_IDLE = 5'b00010,
        S_PLAN = 5'b00100,
        S_WALK = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state        r_state;
    t_cmd          r_cmd;
    logic [7:0]    mem [DEPTH];
    logic [LW-1:0] lens [NUM_SLOTS];
    logic [7:0]    r_rdata;
    logic [LW-1:0] r_ld, r_ls, r_fin, r_cnt, r_k, r_pos;
    logic [AW-1:0] r_dbase, r_sbase, r_init_addr;
    logic          r_wv, r_wmem;
    logic [AW-1:0] r_waddr;
    logic [7:0]    r_wdata;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata;
    logic [LW-1:0] free, n_cnt, n_pos, n_fin;
    logic [8:0]    ls_w, free_w, nb_w;
    logic [2:0]    bit_idx;
    logic [7:0]    byte_val;

    assign o_pop  = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    always_comb begin
        o_rsp            = '0;
        o_rsp.length     = 5'(r_fin);
        o_rsp.illegal_op = r_cmd.illegal;
    end

    // byte store port
    assign we    = (r_state == S_INIT) || r_wv;
    assign waddr = (r_state == S_INIT) ? r_init_addr : r_waddr;
    assign wdata = (r_state == S_INIT) ? 8'h00 : (r_wmem ? r_rdata : r_wdata);
    assign raddr = r_sbase + AW'(r_k);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        // write-first so a self append sees the byte just written
        if (we && waddr == raddr) begin
            r_rdata <= wdata;
        end else begin
            r_rdata <= mem[raddr];
        end
    end

    // command plan
    always_comb begin
        free   = CAP - r_ld;
        ls_w   = 9'(r_ls);
        free_w = 9'(free);
        nb_w   = 9'(r_cmd.nbits);
        n_pos  = r_ld;
        n_cnt  = '0;
        n_fin  = r_ld;
        if (!r_cmd.illegal) begin
            unique case (r_cmd.op)
                OP_CLEAR: begin
                    n_pos = '0;
                    n_cnt = CAP;
                    n_fin = '0;
                end
                OP_FILL: begin
                    if (9'(r_cmd.offset) < 9'(STR_CAPACITY)) begin
                        n_pos = LW'(r_cmd.offset);
                        n_cnt = CAP - LW'(r_cmd.offset);
                        n_fin = CAP;
                    end
                end
                OP_PUTC: begin
                    n_cnt = (r_ld < CAP) ? LW'(1) : '0;
                end
                OP_APPEND: begin
                    if (r_cmd.self_copy) begin
                        n_cnt = (r_ld == '0) ? '0 : free;
                    end else begin
                        n_cnt = (ls_w < free_w) ? r_ls : free;
                    end
                end
                OP_MASK: begin
                    n_cnt = (nb_w < free_w) ? LW'(r_cmd.nbits) : free;
                end
                default: begin
                end
            endcase
            if (r_cmd.op != OP_CLEAR && r_cmd.op != OP_FILL) begin
                n_fin = r_ld + n_cnt;
            end
        end
    end

    // byte produced at walk step r_k
    always_comb begin
        bit_idx  = 3'(r_cmd.nbits - 4'd1 - 4'(r_k));
        byte_val = r_cmd.val;
        if (r_cmd.op == OP_CLEAR) begin
            byte_val = 8'h00;
        end else if (r_cmd.op == OP_MASK) begin
            byte_val = r_cmd.val[bit_idx] ? r_cmd.c1 : r_cmd.c0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_INIT && 32'(r_init_addr) < NUM_SLOTS) begin
            lens[SW'(r_init_addr)] <= '0;
        end else if (r_state == S_DONE) begin
            lens[SW'(r_cmd.dst)] <= r_fin;
        end
        if (r_state == S_IDLE) begin
            r_ld  <= lens[SW'(i_cmd.dst)];
            r_ls  <= lens[SW'(i_cmd.src)];
            r_cmd <= i_cmd;
        end
        if (r_state == S_PLAN) begin
            r_cnt   <= n_cnt;
            r_pos   <= n_pos;
            r_fin   <= n_fin;
            r_k     <= '0;
            r_dbase <= AW'(r_cmd.dst) * AW'(STR_CAPACITY);
            r_sbase <= AW'(r_cmd.src) * AW'(STR_CAPACITY);
        end
        if (r_state == S_WALK && r_k != r_cnt) begin
            r_waddr <= r_dbase + AW'(r_pos);
            r_wdata <= byte_val;
            r_wmem  <= (r_cmd.op == OP_APPEND);
            r_pos   <= r_pos + LW'(1);
            r_k     <= r_k + LW'(1);
        end
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_wv        <= 1'b0;
        end else begin
            r_wv <= (r_state == S_WALK) && (r_k != r_cnt);
            case (r_state)
                S_INIT: begin
                    r_init_addr <= r_init_addr + AW'(1);
                    if (32'(r_init_addr) == DEPTH - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: r_state <= S_WALK;
                S_WALK: begin
                    if (r_k == r_cnt) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/vm_string_buffer_unit.sv */
// ----------------------------------------------------------------------------
// vm_string_buffer_unit
// String opcode unit: clear, length, fill, put char, append, bit mask.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// wait in a queue while the executor works. Each request gives one result on
// o_rsp, flagged by o_done for a single cycle; the result must be taken then.
// The executor writes the bytes of a request one at a time (at most
// STR_CAPACITY), since the byte store has one write port. After reset the
// store is cleared byte by byte, NUM_SLOTS*STR_CAPACITY bytes (480 by
// default); requests are queued meanwhile and run after the sweep.
// ----------------------------------------------------------------------------
module vm_string_buffer_unit import svb_pkg::*; #(
    parameter int STR_CAPACITY = STR_CAPACITY_DEF,
    parameter int NUM_SLOTS    = NUM_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    logic cmd_valid, pop;
    t_cmd cmd;

    svb_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .i_pop       (pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    svb_exec #(
        .STR_CAPACITY (STR_CAPACITY),
        .NUM_SLOTS    (NUM_SLOTS)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

/* tb/sv/vm_string_buffer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vm_string_buffer_unit_tb
// Self-checking bench for the string opcode unit.
// A driver sends queued requests, a shadow string store predicts each
// result, and a monitor compares every strobed result in order.
// ----------------------------------------------------------------------------
module vm_string_buffer_unit_tb;
    import svb_pkg::*;

    localparam int CAP       = 30;
    localparam int SLOTS     = 16;
    localparam int MAX_CYC   = 400000;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    vm_string_buffer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // shadow of the string store
    logic [7:0] shadow_bytes [SLOTS][CAP];
    int         shadow_len   [SLOTS];

    t_req pending_reqs [$];
    t_rsp expected_rsps [$];
    int   gap_pct;
    int   error_count;
    int   cycle_count;
    int   sent_count;
    int   checked_count;

    function automatic void shadow_append(int slot, logic [7:0] ch);
        if (shadow_len[slot] < CAP) begin
            shadow_bytes[slot][shadow_len[slot]] = ch;
            shadow_len[slot]++;
        end
    endfunction

    function automatic t_rsp apply_string_op(t_req r);
        t_rsp res;
        int d;
        int s;
        int j;
        int top;
        d = r.dst_slot;
        s = r.src_slot;
        res.illegal_op = 1'b0;
        case (r.op)
            OP_CLEAR: begin
                shadow_len[d] = 0;
                for (int k = 0; k < CAP; k++) shadow_bytes[d][k] = 8'h00;
            end
            OP_LENGTH: ;
            OP_FILL: begin
                if (r.fill_offset < CAP) begin
                    for (int k = r.fill_offset; k < CAP; k++)
                        shadow_bytes[d][k] = r.value_byte;
                    shadow_len[d] = CAP;
                end
            end
            OP_PUTC: shadow_append(d, r.value_byte);
            OP_APPEND: begin
                // source length read live, so self-append repeats
                j = 0;
                while (shadow_len[d] < CAP && j < shadow_len[s]) begin
                    shadow_append(d, shadow_bytes[s][j]);
                    j++;
                end
            end
            OP_MASK: begin
                top = 7;
                while (top >= 0 && !r.value_byte[top]) top--;
                for (int b = top; b >= 0; b--)
                    shadow_append(d, r.value_byte[b] ? r.one_char : r.zero_char);
            end
            default: res.illegal_op = 1'b1;
        endcase
        res.length = 5'(shadow_len[d]);
        return res;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.op          = 3'($urandom_range(0, 99) < 4 ? $urandom_range(6, 7)
                                                     : $urandom_range(0, 5));
        // few slots so appends meet filled sources
        r.dst_slot    = 4'($urandom_range(0, 99) < 70 ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 15));
        r.src_slot    = 4'($urandom_range(0, 99) < 70 ? $urandom_range(0, 3)
                                                      : $urandom_range(0, 15));
        r.value_byte  = 8'($urandom);
        r.fill_offset = 8'($urandom_range(0, 99) < 70 ? $urandom_range(0, 34)
                                                      : $urandom_range(0, 255));
        r.zero_char   = 8'($urandom);
        r.one_char    = 8'($urandom);
        if (r.op == OP_CLEAR && $urandom_range(0, 1)) r.op = OP_PUTC;
        return r;
    endfunction

    function automatic t_req make_req(logic [2:0] op, int d, int s, int v, int off,
                                      int c0, int c1);
        t_req r;
        r.op = op; r.dst_slot = 4'(d); r.src_slot = 4'(s); r.value_byte = 8'(v);
        r.fill_offset = 8'(off); r.zero_char = 8'(c0); r.one_char = 8'(c1);
        return r;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_req <= '0;
        end else begin
            if (start && !busy) begin
                expected_rsps.push_back(apply_string_op(i_req));
                sent_count++;
            end
            if (!(start && busy)) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
                    start <= 1'b1;
                    i_req <= pending_reqs.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && o_done) begin
            if (expected_rsps.size() == 0) begin
                $error("result with nothing expected: length=%0d illegal_op=%0b",
                       o_rsp.length, o_rsp.illegal_op);
                error_count++;
            end else begin
                t_rsp exp_rsp;
                exp_rsp = expected_rsps.pop_front();
                checked_count++;
                if (o_rsp.length !== exp_rsp.length) begin
                    $error("length: expected %0d, actual %0d", exp_rsp.length, o_rsp.length);
                    error_count++;
                end
                if (o_rsp.illegal_op !== exp_rsp.illegal_op) begin
                    $error("illegal_op: expected %0b, actual %0b",
                           exp_rsp.illegal_op, o_rsp.illegal_op);
                    error_count++;
                end
            end
        end
        if (cycle_count > MAX_CYC) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic run_phase(int pct, int count);
        gap_pct = pct;
        for (int k = 0; k < count; k++) pending_reqs.push_back(random_req());
        wait (pending_reqs.size() == 0 && !start);
    endtask

    initial begin
        error_count = 0; cycle_count = 0; sent_count = 0; checked_count = 0;
        gap_pct = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            shadow_len[s] = 0;
            for (int k = 0; k < CAP; k++) shadow_bytes[s][k] = 8'h00;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        pending_reqs.push_back(make_req(OP_LENGTH, 15, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 1, 2, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_MASK, 0, 0, 8'h00, 0, 8'h30, 8'h31));
        pending_reqs.push_back(make_req(OP_MASK, 0, 0, 8'h01, 0, 8'h30, 8'h31));
        pending_reqs.push_back(make_req(OP_MASK, 0, 0, 8'hA5, 0, 8'h00, 8'hFF));
        pending_reqs.push_back(make_req(OP_MASK, 0, 0, 8'hFF, 0, 8'hFF, 8'h00));
        pending_reqs.push_back(make_req(OP_APPEND, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_PUTC, 0, 0, 8'hFF, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_CLEAR, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_PUTC, 2, 0, 8'h41, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 2, 2, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FILL, 3, 0, 8'hFF, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FILL, 4, 0, 8'h55, 29, 0, 0));
        pending_reqs.push_back(make_req(OP_FILL, 5, 0, 8'h55, 30, 0, 0));
        pending_reqs.push_back(make_req(OP_FILL, 5, 0, 8'h55, 255, 0, 0));
        pending_reqs.push_back(make_req(OP_APPEND, 6, 3, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_MASK, 3, 0, 8'h80, 0, 8'h30, 8'h31));
        pending_reqs.push_back(make_req(3'd6, 3, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 15, 15, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        pending_reqs.push_back(make_req(OP_CLEAR, 3, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_LENGTH, 3, 0, 0, 0, 0, 0));
        wait (pending_reqs.size() == 0 && !start);

        run_phase(36, 150);
        run_phase(76, 150);
        run_phase(0, 150);

        wait (expected_rsps.size() == 0);
        repeat (60) @(posedge i_clk);
        $display("covered %0d requests, %0d results checked, all six ops and illegal codes",
                 sent_count, checked_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
